// ===== src/nearest_point_search_macros.svh =====
// Assertion helpers for the RTL.
`ifndef NEAREST_POINT_SEARCH_MACROS_SVH
`define NEAREST_POINT_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define NPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nearest_point_search: assertion failed");

// Next-cycle implication, disabled during reset.
`define NPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nearest_point_search: assertion failed");

`endif

// ===== src/nps_pkg.sv =====
package nps_pkg;

  localparam int MAX_POINTS = 64;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEARED = 3'd0,
    ST_LOADED  = 3'd1,
    ST_FULL    = 3'd2,
    ST_FOUND   = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } nps_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  nearest_index;
    logic [63:0] min_distance_sq;
  } nps_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  typedef struct packed {
    logic             start;
    logic             valid;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic             busy;
    logic [IDX_W-1:0] idx;
    logic [63:0]      dsq;
  } best_t;

endpackage

// ===== src/nearest_point_search.sv =====
// Channel   Direction  Handshake                 Beat
// in        input      in_valid_i / in_ready_o   nps_in_t  (opcode, pos_x, pos_y, pos_z)
// out       output     out_valid_o / out_ready_i nps_out_t (status, nearest_index, min_distance_sq)
//
// Clear and load: result registered the next cycle; an unused opcode gives no result.
// Query: the points rotate once round the ring of cells past one 3-stage distance
// pipeline; a query with no points loaded answers EMPTY without a scan.
// Reset clears the point count and control; cell contents are kept undefined.
// A new beat is taken while idle and the output register is free or being drained.
`include "nearest_point_search_macros.svh"

module nearest_point_search (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  nps_pkg::nps_in_t in_beat_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nps_pkg::nps_out_t out_beat_o
);
  import nps_pkg::*;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] step_q, step_d;
  point_t           query_q, query_d;
  nps_out_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic             in_acc;
  logic             slot_free;
  logic             is_full;
  logic             load_shift;
  logic             ring_shift;
  logic [CNT_W:0]   pos_sum;
  logic [CNT_W:0]   pos_idx;
  logic [IDX_W+5:0] idx_ext;
  scan_ctl_t        ctl;
  best_t            best;
  point_t           new_point;
  point_t           cell_in  [MAX_POINTS];
  point_t           cell_out [MAX_POINTS];

  assign in_acc    = in_valid_i && in_ready_o;
  assign slot_free = !out_valid_q || out_ready_i;
  assign is_full   = (count_q >= CNT_W'(MAX_POINTS));
  assign new_point = '{x: in_beat_i.pos_x, y: in_beat_i.pos_y, z: in_beat_i.pos_z};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && in_beat_i.opcode == OP_QUERY && count_q != '0) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (step_q == CNT_W'(MAX_POINTS - 1)) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!best.busy) state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = (state_q == S_IDLE) && slot_free;
    load_shift = in_acc && in_beat_i.opcode == OP_LOAD && !is_full;
    ring_shift = (state_q == S_SCAN);
    // entry i sits at ring position MAX_POINTS - count + i
    pos_sum    = {1'b0, step_q} + {1'b0, count_q};
    pos_idx    = pos_sum - (CNT_W + 1)'(MAX_POINTS);
    ctl.start  = in_acc && in_beat_i.opcode == OP_QUERY;
    ctl.valid  = ring_shift && (pos_sum >= (CNT_W + 1)'(MAX_POINTS));
    ctl.idx    = pos_idx[IDX_W-1:0];
  end

  // datapath registers
  always_comb begin
    count_d     = count_q;
    step_d      = step_q;
    query_d     = query_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    idx_ext     = {6'b0, best.idx};

    if (ring_shift) step_d = step_q + CNT_W'(1);

    if (in_acc) begin
      case (in_beat_i.opcode)
        OP_CLEAR: begin
          count_d     = '0;
          out_d       = '{status: ST_CLEARED, nearest_index: '0, min_distance_sq: '0};
          out_valid_d = 1'b1;
        end
        OP_LOAD: begin
          if (!is_full) count_d = count_q + CNT_W'(1);
          out_d       = '{status: is_full ? ST_FULL : ST_LOADED,
                          nearest_index: '0, min_distance_sq: '0};
          out_valid_d = 1'b1;
        end
        OP_QUERY: begin
          query_d = new_point;
          step_d  = '0;
          if (count_q == '0) begin
            out_d       = '{status: ST_EMPTY, nearest_index: '0, min_distance_sq: '0};
            out_valid_d = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (state_q == S_DONE && slot_free) begin
      out_d       = '{status: ST_FOUND, nearest_index: idx_ext[5:0],
                      min_distance_sq: best.dsq};
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q <= query_d;
    out_q   <= out_d;
  end

  // ring of point cells; a load pushes in at cell 0, a scan rotates the ring
  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = load_shift ? new_point : cell_out[MAX_POINTS-1];
    end else begin : g_body
      assign cell_in[k] = cell_out[k-1];
    end
    nps_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (load_shift || ring_shift),
      .point_i (cell_in[k]),
      .point_o (cell_out[k])
    );
  end

  nps_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .query_i (query_q),
    .point_i (cell_out[MAX_POINTS-1]),
    .best_o  (best)
  );

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

  `NPS_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(MAX_POINTS))
  `NPS_ASSERT_IMP(a_done_idle_pipe, clk_i, rst_ni, state_q == S_DONE, !best.busy)
  `NPS_ASSERT_IMP(a_drain_no_feed, clk_i, rst_ni, state_q == S_DRAIN, !ctl.valid)
  `NPS_ASSERT_NXT(a_query_scans, clk_i, rst_ni,
                  ctl.start && count_q != '0, state_q == S_SCAN && step_q == '0)

endmodule

// ===== src/nps_cell.sv =====
module nps_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  nps_pkg::point_t point_i,
  output nps_pkg::point_t point_o
);
  import nps_pkg::*;

  point_t point_q;
  point_t point_d;

  always_comb begin
    point_d = shift_i ? point_i : point_q;
  end

  always_ff @(posedge clk_i) begin
    point_q <= point_d;
  end

  assign point_o = point_q;

endmodule

// ===== src/nps_dist.sv =====
module nps_dist (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nps_pkg::scan_ctl_t ctl_i,
  input  nps_pkg::point_t    query_i,
  input  nps_pkg::point_t    point_i,
  output nps_pkg::best_t     best_o
);
  import nps_pkg::*;

  function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    logic [32:0]        n;
    d = {a[31], a} - {b[31], b};
    n = -d;
    return d[32] ? n[31:0] : d[31:0];
  endfunction

  // stage 1: magnitudes of differences
  logic             v1_q;
  logic [IDX_W-1:0] idx1_q;
  logic [31:0]      mx_q, my_q, mz_q;
  // stage 2: squares
  logic             v2_q;
  logic [IDX_W-1:0] idx2_q;
  logic [63:0]      px_q, py_q, pz_q;
  // stage 3: saturated sum
  logic             v3_q;
  logic [IDX_W-1:0] idx3_q;
  logic [63:0]      sum_q;
  logic [63:0]      sum_d;
  logic [65:0]      wide_sum;
  // running best
  logic             have_q, have_d;
  logic [IDX_W-1:0] bidx_q, bidx_d;
  logic [63:0]      bdist_q, bdist_d;

  always_comb begin
    wide_sum = {2'b00, px_q} + {2'b00, py_q} + {2'b00, pz_q};
    sum_d    = (wide_sum[65:64] != 2'b00) ? '1 : wide_sum[63:0];
  end

  always_comb begin
    have_d  = have_q;
    bidx_d  = bidx_q;
    bdist_d = bdist_q;
    if (ctl_i.start) begin
      have_d = 1'b0;
    end else if (v3_q && (!have_q || sum_q < bdist_q)) begin
      have_d  = 1'b1;
      bidx_d  = idx3_q;
      bdist_d = sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      have_q <= 1'b0;
    end else begin
      v1_q   <= ctl_i.valid;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx1_q  <= ctl_i.idx;
    mx_q    <= abs_diff(query_i.x, point_i.x);
    my_q    <= abs_diff(query_i.y, point_i.y);
    mz_q    <= abs_diff(query_i.z, point_i.z);
    idx2_q  <= idx1_q;
    px_q    <= mx_q * mx_q;
    py_q    <= my_q * my_q;
    pz_q    <= mz_q * mz_q;
    idx3_q  <= idx2_q;
    sum_q   <= sum_d;
    bidx_q  <= bidx_d;
    bdist_q <= bdist_d;
  end

  assign best_o.busy = v1_q | v2_q | v3_q;
  assign best_o.idx  = bidx_q;
  assign best_o.dsq  = bdist_q;

endmodule

// ===== sim/nps_checker.sv =====
module nps_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  nps_pkg::nps_in_t  in_beat_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  nps_pkg::nps_out_t out_beat_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                checked_o,
  output int                full_seen_o,
  output int                sat_seen_o,
  output int                last_slot_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import nps_pkg::*;

  localparam int REPORT_LIMIT = 10;

  logic signed [31:0] tab_x [MAX_POINTS];
  logic signed [31:0] tab_y [MAX_POINTS];
  logic signed [31:0] tab_z [MAX_POINTS];
  int unsigned        tab_count;
  nps_out_t           nearest_q[$];

  function automatic logic [63:0] axis_sq(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    logic [31:0]        mag;
    d   = $signed({a[31], a}) - $signed({b[31], b});
    mag = d[32] ? 32'(-d) : d[31:0];
    return {32'd0, mag} * {32'd0, mag};
  endfunction

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  task automatic predict_nearest(input nps_in_t b);
    nps_out_t    r;
    logic [63:0] d;
    logic [63:0] best_d;
    int unsigned best;
    r      = '0;
    best   = 0;
    best_d = '0;
    case (b.opcode)
      OP_CLEAR: begin
        tab_count = 0;
        r.status  = ST_CLEARED;
        nearest_q = {nearest_q, r};
      end
      OP_LOAD: begin
        if (tab_count >= MAX_POINTS) begin
          r.status = ST_FULL;
        end else begin
          tab_x[tab_count] = b.pos_x;
          tab_y[tab_count] = b.pos_y;
          tab_z[tab_count] = b.pos_z;
          tab_count++;
          r.status = ST_LOADED;
        end
        nearest_q = {nearest_q, r};
      end
      OP_QUERY: begin
        if (tab_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int unsigned i = 0; i < tab_count; i++) begin
            d = axis_sq(b.pos_x, tab_x[i]);
            d = add_sat(d, axis_sq(b.pos_y, tab_y[i]));
            d = add_sat(d, axis_sq(b.pos_z, tab_z[i]));
            if (i == 0 || d < best_d) begin
              best_d = d;
              best   = i;
            end
          end
          r.status          = ST_FOUND;
          r.nearest_index   = best[5:0];
          r.min_distance_sq = best_d;
        end
        nearest_q = {nearest_q, r};
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_result(input nps_out_t got);
    nps_out_t want;
    if (nearest_q.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= REPORT_LIMIT)
        $display("%t: result beat with nothing expected: status %0d idx %0d dist %h",
                 $time, got.status, got.nearest_index, got.min_distance_sq);
    end else begin
      want = nearest_q.pop_front();
      checked_o++;
      if (got.status !== want.status || got.nearest_index !== want.nearest_index ||
          got.min_distance_sq !== want.min_distance_sq) begin
        fail_count_o++;
        if (fail_count_o <= REPORT_LIMIT)
          $display("%t: mismatch: exp status %0d idx %0d dist %h, got status %0d idx %0d dist %h",
                   $time, want.status, want.nearest_index, want.min_distance_sq,
                   got.status, got.nearest_index, got.min_distance_sq);
      end
      if (want.status == ST_FULL) full_seen_o++;
      if (want.status == ST_FOUND && want.min_distance_sq == {64{1'b1}}) sat_seen_o++;
      if (want.status == ST_FOUND && want.nearest_index == 6'd63) last_slot_seen_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_count = 0;
      nearest_q.delete();
      fail_count_o     = 0;
      pending_o        = 0;
      checked_o        = 0;
      full_seen_o      = 0;
      sat_seen_o       = 0;
      last_slot_seen_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_beat_i);
      if (in_valid_i && in_ready_i) predict_nearest(in_beat_i);
      pending_o = nearest_q.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nps_pkg::*;

  localparam logic [1:0]         OP_UNUSED   = 2'd3;
  localparam logic signed [31:0] COORD_MAX   = 32'sh7fff_ffff;
  localparam logic signed [31:0] COORD_MIN   = 32'sh8000_0000;
  localparam int                 ITEM_COUNT  = 1100;
  localparam int                 DRAIN_WAIT  = MAX_POINTS + 16;
  localparam int                 CYCLE_LIMIT = 800_000;
  localparam int                 HOLD_CYCLES = 500;

  typedef enum int {CS_EXTREME, CS_WIDE, CS_GRID, CS_NEAR} coord_style_e;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready;
  nps_in_t  in_beat;
  logic     out_valid;
  logic     out_ready;
  nps_out_t out_beat;

  int fail_count;
  int pending;
  int checked;
  int full_seen;
  int sat_seen;
  int last_slot_seen;

  int n_sent;
  int n_clear;
  int n_load;
  int n_query;
  int n_unused;
  bit no_gaps;
  bit hold_done;
  int cycles;

  nearest_point_search DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_beat_o  (out_beat)
  );

  nps_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_beat_i        (in_beat),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_beat_i       (out_beat),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .checked_o        (checked),
    .full_seen_o      (full_seen),
    .sat_seen_o       (sat_seen),
    .last_slot_seen_o (last_slot_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic nps_in_t make_beat(input logic [1:0] op, input logic signed [31:0] x,
                                        input logic signed [31:0] y,
                                        input logic signed [31:0] z);
    nps_in_t b;
    b.opcode = op;
    b.pos_x  = x;
    b.pos_y  = y;
    b.pos_z  = z;
    return b;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic signed [31:0] pick_coord(input coord_style_e style);
    int v;
    if ($urandom_range(0, 9) == 0) return $urandom;
    case (style)
      CS_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return COORD_MAX;
          1:       return COORD_MIN;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      CS_WIDE: return $urandom;
      CS_GRID: begin
        v = $urandom_range(0, 7);
        return (v - 4) * 65536;
      end
      default: begin
        v = $urandom_range(0, 2 ** 21);
        return v - 2 ** 20;
      end
    endcase
  endfunction

  task automatic send_beat(input nps_in_t b);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_beat  <= make_beat(2'($urandom), $urandom, $urandom, $urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    case (b.opcode)
      OP_CLEAR: n_clear++;
      OP_LOAD:  n_load++;
      OP_QUERY: n_query++;
      default:  n_unused++;
    endcase
    if (b.opcode != OP_UNUSED) n_sent++;
  endtask

  task automatic send_coords(input logic [1:0] op, input coord_style_e style);
    send_beat(make_beat(op, pick_coord(style), pick_coord(style), pick_coord(style)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // receiver: random ready runs, one long hold once traffic is flowing
  initial begin
    int len;
    int r;
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && checked >= 300 && in_valid) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        len = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          out_ready <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (r < 60) begin
          out_ready <= 1'b1;
          len = $urandom_range(40, 120);
        end else if (r < 92) begin
          out_ready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          len = $urandom_range(5, 40);
        end
      end
      repeat (len - 1) @(negedge clk_i);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
    $display("nearest_point_search regression: fail");
    $finish;
  end

  initial begin
    int           seq;
    int           nload;
    int           nq;
    int           r;
    coord_style_e style;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_beat  = '0;
    no_gaps  = 1'b0;
    n_sent   = 0;
    n_clear  = 0;
    n_load   = 0;
    n_query  = 0;
    n_unused = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty query, ignored opcode, extremes, ties, saturation
    send_beat(make_beat(OP_QUERY, 32'sd0, 32'sd0, 32'sd0));
    send_beat(make_beat(OP_UNUSED, $urandom, $urandom, $urandom));
    send_beat(make_beat(OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX));
    send_beat(make_beat(OP_LOAD, COORD_MIN, COORD_MIN, COORD_MIN));
    send_beat(make_beat(OP_LOAD, 32'sd0, 32'sd0, 32'sd0));
    send_beat(make_beat(OP_LOAD, COORD_MIN, COORD_MIN, COORD_MIN));
    send_beat(make_beat(OP_QUERY, 32'sd0, 32'sd0, 32'sd0));
    send_beat(make_beat(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN));
    send_beat(make_beat(OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX));
    send_beat(make_beat(OP_QUERY, COORD_MAX, COORD_MIN, 32'sd0));
    send_beat(make_beat(OP_CLEAR, 32'sd0, 32'sd0, 32'sd0));
    send_beat(make_beat(OP_LOAD, COORD_MIN, COORD_MIN, COORD_MIN + 1));
    send_beat(make_beat(OP_LOAD, COORD_MIN, COORD_MIN, COORD_MIN));
    send_beat(make_beat(OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX));
    send_beat(make_beat(OP_QUERY, COORD_MIN, COORD_MIN, COORD_MIN));
    send_beat(make_beat(OP_UNUSED, -32'sd1, -32'sd1, -32'sd1));
    send_beat(make_beat(OP_CLEAR, -32'sd1, -32'sd1, -32'sd1));
    send_beat(make_beat(OP_QUERY, 32'sd0, 32'sd0, 32'sd0));
    send_beat(make_beat(OP_CLEAR, COORD_MAX, COORD_MIN, COORD_MAX));
    send_beat(make_beat(OP_LOAD, 32'sd65536, -32'sd65536, 32'sd1));
    send_beat(make_beat(OP_QUERY, -32'sd1, -32'sd1, -32'sd1));
    wait_drained();

    // random: clear (most runs), fill, then query bursts; some runs overfill the table
    seq = 0;
    while (n_sent < ITEM_COUNT) begin
      seq++;
      if (seq % 8 == 0) wait_drained();
      no_gaps = ($urandom_range(0, 3) == 0);
      style   = coord_style_e'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 7) send_coords(OP_CLEAR, CS_WIDE);
      r = $urandom_range(0, 9);
      if (r == 0) nload = 0;
      else if (r < 3) nload = $urandom_range(60, 70);
      else nload = $urandom_range(1, 24);
      for (int i = 0; i < nload; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4) send_coords(OP_UNUSED, CS_WIDE);
        else if (r < 8) send_coords(OP_QUERY, style);
        send_coords(OP_LOAD, style);
      end
      nq = $urandom_range(1, 8);
      for (int i = 0; i < nq; i++) send_coords(OP_QUERY, style);
    end

    no_gaps = 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk_i);

    $display("covered %0d beats: %0d clears, %0d loads, %0d queries, %0d ignored opcodes",
             n_sent + n_unused, n_clear, n_load, n_query, n_unused);
    $display("%0d results checked: %0d table-full drops, %0d saturated, %0d on slot 63",
             checked, full_seen, sat_seen, last_slot_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("nearest_point_search regression: pass");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, pending);
      $display("nearest_point_search regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/nps_pkg.sv
src/nps_cell.sv
src/nps_dist.sv
src/nearest_point_search.sv
sim/nps_checker.sv
sim/tb_top.sv
